// ----- sv/sons_pkg.sv -----
// Package for the sparse octree node store: item types, kinds, sizes.
// No dependencies.
package sons_pkg;
    localparam int NodeSlots = 65536;
    localparam int MaxDepth  = 12;
    localparam int NodeW     = 16;
    localparam int CountW    = 17;
    localparam int QDepth    = 2;

    typedef enum logic [2:0] {
        K_CLEAR  = 3'd0,
        K_INS_PT = 3'd1,
        K_INS_PA = 3'd2,
        K_REMOVE = 3'd3,
        K_LOOKUP = 3'd4
    } t_kind;

    typedef struct packed {
        logic [2:0]  kind;
        logic [11:0] coord_x;
        logic [11:0] coord_y;
        logic [11:0] coord_z;
        logic [23:0] model_tag;
        logic [35:0] octet_path;
        logic [15:0] start_node;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic [23:0] leaf_tag;
        logic [15:0] parent_node;
        logic [3:0]  first_new_level;
        logic [15:0] first_new_parent;
        logic [16:0] used_nodes;
        logic        table_full;
        logic [35:0] walked_path;
    } t_out_item;

    // classified command passed from front to back
    typedef struct packed {
        logic [2:0]  kind;
        logic [35:0] path;
        logic [23:0] tag;
        logic [15:0] start;
        logic [3:0]  depth;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE, S_CHK, S_RD, S_EVAL, S_TAG, S_DONE
    } t_state;
endpackage

// ----- sv/sons_front.sv -----
// Front end: accepts items, builds the octet path, queues commands.
// Depends on sons_pkg.
module sons_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  sons_pkg::t_in_item i_item,
    input  logic [3:0]        i_depth,
    output logic              o_cmd_valid,
    input  logic              i_cmd_take,
    output sons_pkg::t_cmd    o_cmd
);
    import sons_pkg::*;

    t_cmd       r_q [QDepth];
    logic [0:0] r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       n_cmd;
    logic [3:0] d;
    logic       push;

    always_comb begin
        d = i_depth;
        if (d == 4'd0) d = 4'd1;
        if (d > 4'(MaxDepth)) d = 4'(MaxDepth);
        n_cmd.kind  = i_item.kind;
        n_cmd.tag   = i_item.model_tag;
        n_cmd.start = i_item.start_node;
        n_cmd.depth = d;
        n_cmd.path  = i_item.octet_path;
        if (i_item.kind != K_INS_PA) begin
            // level L uses coordinate bit D-1-L; y and z inverted
            for (int l = 0; l < MaxDepth; l++) begin
                if (l < int'(d)) begin
                    n_cmd.path[3*l]   = i_item.coord_x[4'(int'(d) - 1 - l)];
                    n_cmd.path[3*l+1] = ~i_item.coord_y[4'(int'(d) - 1 - l)];
                    n_cmd.path[3*l+2] = ~i_item.coord_z[4'(int'(d) - 1 - l)];
                end else begin
                    n_cmd.path[3*l +: 3] = 3'd0;
                end
            end
        end
    end

    assign o_stall     = (r_cnt == 2'(QDepth));
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (i_cmd_take) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + 2'(push) - 2'(i_cmd_take);
        end
        if (push) r_q[r_wp] <= n_cmd;
    end
endmodule

// ----- sv/sons_back.sv -----
// Back end: walks the node table one level at a time.
// Depends on sons_pkg.
module sons_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_take,
    input  sons_pkg::t_cmd     i_cmd,
    output logic               o_valid,
    input  logic               i_stall,
    output sons_pkg::t_out_item o_item
);
    import sons_pkg::*;

    logic [NodeW-1:0] links_mem [NodeSlots*8];
    logic [23:0]      tags_mem  [NodeSlots];
    logic [7:0]       r_root_ok;   // root links valid bits

    t_state r_st, n_st;
    t_cmd   r_cmd;
    t_out_item r_res;
    logic [CountW-1:0] r_count;
    logic [NodeW-1:0]  r_node, r_parent;
    logic [3:0]        r_lvl;
    logic [2:0]        r_poct;
    logic              r_first, r_ok, r_out_v;
    logic [NodeW-1:0]  r_rd;
    logic [23:0]       r_tag_rd;

    logic [2:0]  oct;
    logic [NodeW-1:0] link;
    logic        is_ins, w_en, t_en;
    logic [18:0] w_addr, rd_addr;
    logic [NodeW-1:0] w_data;
    logic [15:0] t_addr;

    assign oct    = r_cmd.path[3*r_lvl +: 3];
    assign is_ins = (r_cmd.kind == K_INS_PT) || (r_cmd.kind == K_INS_PA);
    assign link   = (r_node == '0 && !r_root_ok[oct]) ? '0 : r_rd;
    assign rd_addr = {r_node, oct};
    assign o_valid = r_out_v;
    assign o_item  = r_res;
    assign o_cmd_take = (r_st == S_IDLE) && i_cmd_valid && !r_out_v;

    always_comb begin
        n_st = r_st;
        w_en = 1'b0; w_addr = rd_addr; w_data = '0;
        t_en = 1'b0; t_addr = r_count[15:0];
        case (r_st)
            S_IDLE: if (o_cmd_take) n_st = S_CHK;
            S_CHK:  n_st = (r_cmd.kind == K_CLEAR || r_cmd.kind > K_LOOKUP ||
                            (is_ins && 17'(r_cmd.start) >= r_count)) ? S_DONE : S_RD;
            S_RD:   n_st = S_EVAL;
            S_EVAL: begin
                if (is_ins) begin
                    if (link == '0) begin
                        if (r_count == CountW'(NodeSlots)) n_st = S_DONE;
                        else begin
                            w_en = 1'b1; w_data = r_count[15:0];
                            t_en = 1'b1;
                            n_st = S_TAG;
                        end
                    end else n_st = (r_lvl + 1'b1 == r_cmd.depth) ? S_DONE : S_RD;
                end else begin
                    if (!r_ok || r_lvl + 1'b1 == r_cmd.depth) begin
                        n_st = S_DONE;
                        if (r_ok && link != '0 && r_cmd.kind == K_REMOVE) w_en = 1'b1;
                    end else n_st = S_RD;
                end
            end
            S_TAG: begin
                // clear the new node's links one per cycle, indexed by r_poct
                w_en = 1'b1; w_addr = {r_count[15:0] - 16'd1, r_poct};
                if (r_poct == 3'd7)
                    n_st = (r_lvl == r_cmd.depth) ? S_DONE : S_RD;
            end
            S_DONE: if (!r_out_v) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) links_mem[w_addr] <= w_data;
        if (t_en) tags_mem[t_addr] <= r_cmd.tag;
        r_rd <= links_mem[rd_addr];
        r_tag_rd <= tags_mem[link];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_out_v <= 1'b0; r_count <= CountW'(1); r_root_ok <= '0;
        end else begin
            r_st <= n_st;
            if (r_out_v && !i_stall) r_out_v <= 1'b0;
            if (w_en && w_addr[18:3] == '0) r_root_ok[w_addr[2:0]] <= 1'b1;
            case (r_st)
                S_IDLE: if (o_cmd_take) begin
                    r_cmd <= i_cmd;
                    r_res <= '{first_new_level: i_cmd.depth, default: '0};
                    r_lvl <= '0; r_first <= 1'b1; r_ok <= 1'b1;
                    r_node <= (i_cmd.kind == K_INS_PT || i_cmd.kind == K_INS_PA) ?
                              i_cmd.start : '0;
                end
                S_CHK: if (r_cmd.kind == K_CLEAR) begin
                    r_count <= CountW'(1); r_root_ok <= '0;
                end else if (r_cmd.kind == K_REMOVE || r_cmd.kind == K_LOOKUP)
                    r_res.walked_path <= r_cmd.path;
                S_EVAL: begin
                    if (is_ins) begin
                        if (link == '0) begin
                            if (r_count == CountW'(NodeSlots)) r_res.table_full <= 1'b1;
                            else begin
                                if (r_first) begin
                                    r_res.first_new_level <= r_lvl;
                                    r_res.first_new_parent <= r_node;
                                    r_first <= 1'b0;
                                end
                                r_res.walked_path[3*r_lvl +: 3] <= oct;
                                r_node <= r_count[15:0];
                                r_count <= r_count + 1'b1;
                                r_poct <= 3'd0;
                                r_lvl <= r_lvl + 1'b1;
                            end
                        end else begin
                            r_res.walked_path[3*r_lvl +: 3] <= oct;
                            r_node <= link; r_lvl <= r_lvl + 1'b1;
                        end
                    end else if (r_ok) begin
                        r_parent <= r_node; r_node <= link;
                        if (link == '0) r_ok <= 1'b0;
                        r_lvl <= r_lvl + 1'b1;
                    end
                end
                S_TAG: r_poct <= r_poct + 1'b1;
                S_DONE: if (!r_out_v) begin
                    r_out_v <= 1'b1;
                    r_res.used_nodes <= r_count;
                    if (!is_ins && r_ok && r_node != '0 && r_cmd.kind != K_CLEAR &&
                        r_cmd.kind <= K_LOOKUP) begin
                        r_res.found <= 1'b1;
                        r_res.leaf_tag <= (r_node == '0) ? 24'd0 : r_tag_rd;
                        r_res.parent_node <= r_parent;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// ----- sv/sparse_octree_node_store.sv -----
// Top level of the sparse octree node store: config register, front, back.
// Depends on sons_pkg, sons_front, sons_back.
//
//  channel | handshake          | payload
//  in      | i_valid / o_stall  | i_in (t_in_item)
//  out     | o_valid / i_stall  | o_out (t_out_item)
//  cfg     | i_cfg_valid/o_cfg_ready | i_cfg_data (depth_in_use)
//
// Each level walked passes S_RD and S_EVAL, as the link memory read in the
// walk loop is registered; each allocated node also clears its links in S_TAG.
// A remove or lookup missing above the leaf level does one more read pair.
// Reset clears node count, root links and queues; no clearing pass.
// A two-entry queue lets the front accept while the back is busy.
module sparse_octree_node_store (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  sons_pkg::t_in_item  i_in,
    output logic                o_valid,
    input  logic                i_stall,
    output sons_pkg::t_out_item o_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [3:0]          i_cfg_data
);
    import sons_pkg::*;

    logic [3:0] r_depth;
    logic       cmd_v, cmd_take;
    t_cmd       cmd;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_depth <= 4'd12;
        else if (i_cfg_valid) r_depth <= i_cfg_data;
    end

    sons_front u_front (.i_clk, .i_rst_n, .i_valid, .o_stall, .i_item(i_in),
        .i_depth(r_depth), .o_cmd_valid(cmd_v), .i_cmd_take(cmd_take), .o_cmd(cmd));
    sons_back u_back (.i_clk, .i_rst_n, .i_cmd_valid(cmd_v), .o_cmd_take(cmd_take),
        .i_cmd(cmd), .o_valid, .i_stall, .o_item(o_out));

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out)) else $error("out dropped");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_take |-> cmd_v) else $error("take from empty queue");
endmodule
